// File: hdl/crc32k_pkg.sv
// Shared types, constants and CRC table function for the CRC-32 frame engine.
package crc32k_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned CRC_W      = 32;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned S_TDATA_W  = 40;   // data_byte, expected_crc
    localparam int unsigned M_TDATA_W  = 48;   // crc_value, out_byte, crc_match, pad

    localparam logic [CRC_W-1:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_XOROUT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY_REF = 32'hD663_B05D;

    // Finishing modes carried with the last byte of a frame
    localparam logic [MODE_W-1:0] MODE_CALC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd2;

    typedef enum logic [1:0] {
        KIND_CALC,
        KIND_CHECK,
        KIND_APPEND
    } job_kind_t;

    // One finished frame handed from the front to the back
    typedef struct packed {
        job_kind_t           kind;
        logic [CRC_W-1:0]    crc;
        logic [CRC_W-1:0]    expected;
    } job_t;

    // Byte table entry: eight reflected shift steps on an 8-bit index
    function automatic logic [CRC_W-1:0] crc_table_entry(input logic [DATA_W-1:0] idx);
        logic [CRC_W-1:0] r;
        r = {{(CRC_W-DATA_W){1'b0}}, idx};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REF) : (r >> 1);
        end
        return r;
    endfunction

    // Fold one byte into the running register
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
        return (crc >> DATA_W) ^ crc_table_entry(crc[DATA_W-1:0] ^ b);
    endfunction

endpackage

// File: hdl/crc32k_front.sv
// Front end: accepts frame bytes, runs the CRC and posts a job per finished frame.
module crc32k_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [crc32k_pkg::DATA_W-1:0] data_byte,
    input  logic [crc32k_pkg::CRC_W-1:0]  expected_crc,
    input  logic [crc32k_pkg::MODE_W-1:0] mode,
    input  logic                         last_byte,
    input  logic                         q_full,
    output logic                         push,
    output crc32k_pkg::job_t             push_job
);
    import crc32k_pkg::*;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_fold_val;
    logic             accept;
    job_kind_t        kind;

    // Stall only while the job queue has no room
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign crc_fold_val = crc_fold(crc_reg, data_byte);

    // Classify the finishing mode; the unused code falls back to calculate
    always_comb
    begin
        case (mode)
            MODE_CHECK:  kind = KIND_CHECK;
            MODE_APPEND: kind = KIND_APPEND;
            default:     kind = KIND_CALC;
        endcase
    end

    // Advance the register, restart it after the last byte
    always_comb
    begin
        crc_next = crc_reg;
        if (accept) begin
            crc_next = last_byte ? CRC_INIT : crc_fold_val;
        end
    end

    assign push              = accept && last_byte;
    assign push_job.kind     = kind;
    assign push_job.crc      = crc_fold_val ^ CRC_XOROUT;
    assign push_job.expected = expected_crc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

// File: hdl/crc32k_queue.sv
// Short job queue between the front and back ends.
module crc32k_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  crc32k_pkg::job_t push_job,
    output logic             full,
    input  logic             pop,
    output crc32k_pkg::job_t head_job,
    output logic             empty
);
    import crc32k_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/crc32k_back.sv
// Back end: turns queued jobs into result requests through an output register.
module crc32k_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crc32k_pkg::job_t              head_job,
    input  logic                          empty,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [crc32k_pkg::CRC_W-1:0]  crc_value,
    output logic [crc32k_pkg::DATA_W-1:0] out_byte,
    output logic                          crc_match,
    output logic                          last_result
);
    import crc32k_pkg::*;

    logic              valid_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [DATA_W-1:0] byte_reg;
    logic              match_reg;
    logic              last_reg;
    logic [1:0]        idx_reg, idx_next;
    logic              load;
    logic [DATA_W-1:0] byte_sel;
    logic              final_item;

    // Refill the output register whenever a job waits and the register is empty or being drained
    assign load = !empty && (!valid_reg || m_tready);

    // Pick the CRC byte, most significant first
    always_comb
    begin
        case (idx_reg)
            2'd0:    byte_sel = head_job.crc[31:24];
            2'd1:    byte_sel = head_job.crc[23:16];
            2'd2:    byte_sel = head_job.crc[15:8];
            default: byte_sel = head_job.crc[7:0];
        endcase
    end

    assign final_item = (head_job.kind != KIND_APPEND) || (idx_reg == 2'd3);
    assign pop        = load && final_item;

    always_comb
    begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = final_item ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Capture the result request
    always_ff @(posedge clk)
    begin
        if (load) begin
            crc_reg   <= head_job.crc;
            byte_reg  <= (head_job.kind == KIND_APPEND) ? byte_sel : '0;
            match_reg <= (head_job.kind == KIND_CHECK) && (head_job.crc == head_job.expected);
            last_reg  <= final_item;
        end
    end

    assign m_tvalid    = valid_reg;
    assign crc_value   = crc_reg;
    assign out_byte    = byte_reg;
    assign crc_match   = match_reg;
    assign last_result = last_reg;

endmodule

// File: hdl/crc32_koopman_calc_check_append_top.sv
// Top level of the CRC-32 (poly 0xBA0DC66B) calculate / check / append engine.
// Throughput: one data byte accepted per cycle unless the job queue is full; results leave at
// one per cycle while jobs wait and m_tready is high. The last byte of a frame posts a job to
// the queue, whose head the back end loads into the output register. Append mode yields four
// result requests per frame, set by the back-end byte counter. Reset (rst_n low, asynchronous)
// restores the CRC register to all ones and empties the job queue and output register.
module crc32_koopman_calc_check_append_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [crc32k_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] data_byte, [39:8] expected_crc
    input  logic [crc32k_pkg::MODE_W-1:0]       s_tuser,  // [1:0] mode
    input  logic                                s_tlast,  // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [crc32k_pkg::M_TDATA_W-1:0]    m_tdata,  // [31:0] crc_value, [39:32] out_byte,
                                                          // [40] crc_match, [47:41] zero
    output logic                                m_tlast   // last_result
);
    import crc32k_pkg::*;

    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    job_t              push_job;
    job_t              head_job;
    logic [CRC_W-1:0]  crc_value;
    logic [DATA_W-1:0] out_byte;
    logic              crc_match;

    crc32k_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .data_byte    (s_tdata[7:0]),
        .expected_crc (s_tdata[39:8]),
        .mode         (s_tuser),
        .last_byte    (s_tlast),
        .q_full       (q_full),
        .push         (push),
        .push_job     (push_job)
    );

    crc32k_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    crc32k_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .empty       (q_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .crc_value   (crc_value),
        .out_byte    (out_byte),
        .crc_match   (crc_match),
        .last_result (m_tlast)
    );

    // Pack the result fields, lowest first
    assign m_tdata = {7'd0, crc_match, out_byte, crc_value};

endmodule

// File: hdl/crc32k_check.sv
// Port-level checker for the CRC-32 engine, bound to the top level.
module crc32k_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [crc32k_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);
    import crc32k_pkg::*;

    // No result request on the edge after one seen in reset
    a_idle_in_reset: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result request shown during reset");

    // A stalled result request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result request changed");

    // Only append frames give non-final results, and those carry no match flag
    a_mid_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tdata[40])
        else $error("match flag on a non-final result");

    // Append bytes follow back to back with the same CRC
    a_append_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tdata[31:0]))
        else $error("append run broken");

    // A match flag implies no append byte
    a_match_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |-> m_tdata[39:32] == 8'd0)
        else $error("append byte on a check result");

endmodule

bind crc32_koopman_calc_check_append_top crc32k_check u_crc32k_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/crc32_koopman_calc_check_append_checker.sv
// Checker for the CRC-32 frame engine: predicts each result request and compares it.
`timescale 1ns / 100ps

module crc32_koopman_calc_check_append_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [crc32k_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] data_byte, [39:8] expected_crc
    input  logic [crc32k_pkg::MODE_W-1:0]       s_tuser,  // [1:0] mode
    input  logic                                s_tlast,  // last_byte
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [crc32k_pkg::M_TDATA_W-1:0]    m_tdata,  // [31:0] crc_value, [39:32] out_byte,
                                                          // [40] crc_match, [47:41] zero
    input  logic                                m_tlast,  // last_result
    output int                                  mismatch_count,
    output int                                  results_waiting,
    output int                                  results_checked,
    output logic [31:0]                         frame_crc
);

    import crc32k_pkg::*;

    typedef struct packed {
        logic [31:0] crc_value;
        logic [7:0]  out_byte;
        logic        crc_match;
        logic        last_result;
    } crc_result_t;

    crc_result_t      crc_results_q[$];
    crc_result_t      want;
    logic [31:0]      running_crc = CRC_INIT;
    logic [31:0]      finished_crc;
    bit               bad;

    initial
    begin
        mismatch_count  = 0;
        results_waiting = 0;
        results_checked = 0;
        frame_crc       = 32'h0;
    end

    // Fold one byte into the running CRC, least significant bit first
    function automatic logic [31:0] fold_crc_byte(input logic [31:0] r, input logic [7:0] b);
        r = r ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REF) : (r >> 1);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc = CRC_INIT;
            crc_results_q.delete();
            results_waiting = 0;
        end
        else
        begin
            // Advance the prediction on each accepted byte; finish the frame on the last one
            if (s_tvalid && s_tready)
            begin
                running_crc = fold_crc_byte(running_crc, s_tdata[7:0]);
                if (s_tlast)
                begin
                    finished_crc = running_crc ^ CRC_XOROUT;
                    running_crc  = CRC_INIT;
                    frame_crc    = finished_crc;
                    if (s_tuser == MODE_CHECK)
                    begin
                        crc_results_q.push_back({finished_crc, 8'h00,
                                                 finished_crc == s_tdata[39:8], 1'b1});
                    end
                    else if (s_tuser == MODE_APPEND)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            crc_results_q.push_back({finished_crc,
                                                     8'(finished_crc >> (24 - 8 * k)),
                                                     1'b0, k == 3});
                        end
                    end
                    else
                    begin
                        // calculate, and the undefined mode treated the same way
                        crc_results_q.push_back({finished_crc, 8'h00, 1'b0, 1'b1});
                    end
                end
            end

            // Compare each accepted result request against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (crc_results_q.size() == 0)
                begin
                    $error("unexpected result request: crc_value %h", m_tdata[31:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = crc_results_q.pop_front();
                    bad  = 1'b0;
                    if (m_tdata[31:0] !== want.crc_value)
                    begin
                        $error("crc_value: expected %h, got %h", want.crc_value, m_tdata[31:0]);
                        bad = 1'b1;
                    end
                    if (m_tdata[39:32] !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte, m_tdata[39:32]);
                        bad = 1'b1;
                    end
                    if (m_tdata[40] !== want.crc_match)
                    begin
                        $error("crc_match: expected %b, got %b", want.crc_match, m_tdata[40]);
                        bad = 1'b1;
                    end
                    if (m_tlast !== want.last_result)
                    begin
                        $error("last_result: expected %b, got %b", want.last_result, m_tlast);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatch_count++;
                end
            end
            results_waiting = crc_results_q.size();
        end
    end

endmodule

// File: tb/crc32_koopman_calc_check_append_top_tb.sv
// Testbench top for the CRC-32 frame engine: stimulus, receiver pacing and verdict.
`timescale 1ns / 100ps

module crc32_koopman_calc_check_append_top_tb;

    import crc32k_pkg::*;

    localparam int unsigned       CYCLE_LIMIT = 200000;
    localparam int unsigned       HOLD_CYCLES = 300;
    localparam logic [MODE_W-1:0] MODE_UNDEF  = 2'd3;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE
    } rx_style_t;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;
    logic [MODE_W-1:0]       s_tuser  = '0;
    logic                    s_tlast  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tlast;

    int                      mismatch_count;
    int                      results_waiting;
    int                      results_checked;
    logic [31:0]             frame_crc;

    // Stimulus state
    logic [7:0]              frame_buf [0:31];
    int                      frame_len     = 0;
    int                      bytes_sent    = 0;
    int                      frames_sent   = 0;
    int                      burst_left    = 0;
    bit                      use_gaps      = 1'b0;
    rx_style_t               rx_style      = RX_ALWAYS;
    int                      hold_requests = 0;

    // Receiver state
    int                      holds_served  = 0;
    int                      hold_left     = 0;
    logic [1:0]              rx_phase      = 2'd0;
    int unsigned             cycle_count   = 0;

    crc32_koopman_calc_check_append_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    crc32_koopman_calc_check_append_checker crc_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .results_waiting (results_waiting),
        .results_checked (results_checked),
        .frame_crc       (frame_crc)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abandon the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Pace the result side: a long hold on request, otherwise the current stall style
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else
        begin
            case (rx_style)
                RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= (rx_phase == 2'd0);
                default:   m_tready <= 1'b1;
            endcase
            rx_phase <= rx_phase + 2'd1;
        end
    end

    // Fill the frame buffer with random bytes
    task automatic fill_frame(input int len);
        frame_len = len;
        for (int i = 0; i < len; i++)
            frame_buf[i] = 8'($urandom_range(0, 255));
    endtask

    // Send the buffered frame; the last byte carries the mode and, for a repeated
    // frame, the CRC just predicted for it with an optional bit flip
    task automatic send_frame(input logic [MODE_W-1:0] finish_mode, input bit reuse_crc,
                              input logic [31:0] crc_flip, input logic [31:0] given_crc);
        logic [31:0]       exp_word;
        logic [MODE_W-1:0] mode_word;
        logic              last_word;
        int                gap;
        for (int i = 0; i < frame_len; i++)
        begin
            @(negedge clk);
            last_word = (i == frame_len - 1);
            if (last_word)
            begin
                mode_word = finish_mode;
                exp_word  = reuse_crc ? (frame_crc ^ crc_flip) : given_crc;
            end
            else
            begin
                mode_word = MODE_W'($urandom_range(0, 3));
                exp_word  = $urandom;
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {exp_word, frame_buf[i]};
            s_tuser  <= mode_word;
            s_tlast  <= last_word;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            bytes_sent++;
            if (last_word)
                frames_sent++;
            // Insert a gap once the current burst runs out
            if (use_gaps)
            begin
                if (burst_left == 0)
                begin
                    gap = $urandom_range(1, 6);
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                    burst_left = $urandom_range(1, 12);
                end
                else
                begin
                    burst_left--;
                end
            end
        end
    endtask

    // Random frames, mostly short; some are repeated in check mode to hit a match
    task automatic random_frames(input int n_bytes);
        int          start;
        int          len;
        logic [31:0] flip;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            fill_frame(len);
            if ($urandom_range(0, 3) == 0)
            begin
                send_frame($urandom_range(0, 1) ? MODE_CALC : MODE_APPEND, 1'b0, 32'h0, $urandom);
                flip = $urandom_range(0, 1) ? 32'h0 : (32'h1 << $urandom_range(0, 31));
                send_frame(MODE_CHECK, 1'b1, flip, 32'h0);
            end
            else
            begin
                send_frame(MODE_W'($urandom_range(0, 3)), 1'b0, 32'h0, $urandom);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one-, three- and four-byte frames, extreme bytes, every mode including the undefined one
        frame_len    = 1;
        frame_buf[0] = 8'h00;
        send_frame(MODE_CALC, 1'b0, 32'h0, 32'h0);
        frame_buf[0] = 8'hFF;
        send_frame(MODE_APPEND, 1'b0, 32'h0, 32'hFFFF_FFFF);
        frame_buf[0] = 8'h5A;
        send_frame(MODE_UNDEF, 1'b0, 32'h0, $urandom);
        frame_len    = 3;
        frame_buf[0] = 8'h00;
        frame_buf[1] = 8'hFF;
        frame_buf[2] = 8'hA5;
        send_frame(MODE_CALC, 1'b0, 32'h0, 32'h0);
        send_frame(MODE_CHECK, 1'b1, 32'h0, 32'h0);
        send_frame(MODE_CHECK, 1'b1, 32'h8000_0000, 32'h0);
        frame_len = 4;
        for (int i = 0; i < 4; i++)
            frame_buf[i] = 8'hFF;
        send_frame(MODE_APPEND, 1'b0, 32'h0, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            frame_buf[i] = 8'h00;
        send_frame(MODE_CHECK, 1'b0, 32'h0, 32'h0);

        // Random traffic with bursty sender and randomly stalling receiver
        use_gaps = 1'b1;
        rx_style = RX_RANDOM;
        random_frames(150);

        // Back-pressure: hold the result side while append frames keep coming
        use_gaps = 1'b0;
        rx_style = RX_ALWAYS;
        hold_requests++;
        for (int n = 0; n < 10; n++)
        begin
            fill_frame($urandom_range(1, 4));
            send_frame(MODE_APPEND, 1'b0, 32'h0, $urandom);
        end
        random_frames(50);

        // Sparse receiver with bursty sender
        use_gaps = 1'b1;
        rx_style = RX_SPARSE;
        random_frames(200);

        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain, then keep watching for anything stray before the verdict
        do
            @(negedge clk);
        while (results_waiting != 0);
        repeat (10) @(negedge clk);

        $display("summary: %0d bytes in %0d frames sent, %0d result requests checked",
                 bytes_sent, frames_sent, results_checked);
        $display("summary: all modes, repeated frames in check mode, one long output hold");
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
hdl/crc32k_pkg.sv
hdl/crc32k_front.sv
hdl/crc32k_queue.sv
hdl/crc32k_back.sv
hdl/crc32_koopman_calc_check_append_top.sv
hdl/crc32k_check.sv
tb/crc32_koopman_calc_check_append_checker.sv
tb/crc32_koopman_calc_check_append_top_tb.sv
